// File: hw/rtl/cps_pkg.sv
// Package for the cart-pole step core: constants, types and helpers.
package cps_pkg;

  localparam int unsigned MaxSteps = 500;
  localparam int unsigned CntW = 16;
  localparam int unsigned CordicIters = 24;
  localparam int unsigned CordicIdxW = 5;
  localparam int unsigned DivIters = 48;
  localparam int unsigned DivIdxW = 6;
  localparam int unsigned RedIters = 3;

  localparam logic signed [31:0] FourThirdsQ = 32'sd87381;
  localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiQ30 = 36'sd6746518852;
  localparam logic signed [35:0] CordicGain = 36'sd652032874;
  // just under 2^63 / TwoPiQ30, so the quotient estimate is never too high
  localparam logic signed [31:0] RecipTwoPiQ30 = 32'sd1367130500;

  localparam logic [2:0] RegForce = 3'd0;
  localparam logic [2:0] RegGrav = 3'd1;
  localparam logic [2:0] RegMass = 3'd2;
  localparam logic [2:0] RegInvM = 3'd3;
  localparam logic [2:0] RegLen = 3'd4;
  localparam logic [2:0] RegTau = 3'd5;
  localparam logic [2:0] RegXLim = 3'd6;
  localparam logic [2:0] RegALim = 3'd7;

  localparam logic [0:0] OpStep = 1'b0;
  localparam logic [0:0] OpLoad = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RED  = 6'b000010,
    ST_CORD = 6'b000100,
    ST_MATH = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  function automatic logic [35:0] atan_q30(input logic [CordicIdxW-1:0] i);
    logic [35:0] v;
    unique case (i)
      5'd0: v = 36'd843314856;  5'd1: v = 36'd497837829;
      5'd2: v = 36'd263043836;  5'd3: v = 36'd133525158;
      5'd4: v = 36'd67021686;   5'd5: v = 36'd33543515;
      5'd6: v = 36'd16775850;   5'd7: v = 36'd8388437;
      5'd8: v = 36'd4194282;    5'd9: v = 36'd2097149;
      5'd10: v = 36'd1048575;   5'd11: v = 36'd524287;
      5'd12: v = 36'd262143;    5'd13: v = 36'd131071;
      5'd14: v = 36'd65535;     5'd15: v = 36'd32767;
      5'd16: v = 36'd16383;     5'd17: v = 36'd8191;
      5'd18: v = 36'd4095;      5'd19: v = 36'd2047;
      5'd20: v = 36'd1023;      5'd21: v = 36'd511;
      5'd22: v = 36'd255;       5'd23: v = 36'd127;
      default: v = 36'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/cart_pole_physics_step_core.sv
// Cart-pole Euler step core: sequencer around one shared multiply/add unit.
//  channel | dir | handshake            | payload
//  in_     | in  | tvalid/tready        | tuser=opcode, tdata={start_rate..push_right}
//  out_    | out | tvalid/tready        | tdata={done,reward,rate,angle,vel,pos}
//  cfg_    | in  | APB psel/penable     | 8 registers at 4*i
// A load answers in the cycle after its beat. A step runs angle reduction
// (reciprocal multiply, remainder, fold), 24 CORDIC rotations and 18 ops on
// the one shared 32x32 multiplier, with a restoring divider between ops 10 and
// 11. At the step limit it answers after the reduction alone. Reset is synchronous;
// it clears state and counter and loads register defaults. No item is taken
// while one is in work or while its result waits in the output register.
module cart_pole_physics_step_core
  import cps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [0:0]   in_tuser,  // opcode
  // push_right[0], start_position[32:1], start_velocity[64:33],
  // start_angle[96:65], start_rate[128:97]; zero fill to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // position[31:0], velocity[63:32], angle[95:64], angular_rate[127:96],
  // reward[128], done_res[129]; zero fill to 136
  output logic [135:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [30:0] regs_r [8];
  state_t state_r, state_nxt;
  logic signed [31:0] pos_r, vel_r, ang_r, rate_r;
  logic [CntW-1:0] cnt_r;
  logic push_r, reward_r, done_r;
  logic signed [35:0] cx_r, cy_r, cz_r;
  logic flip_r;
  logic [CordicIdxW-1:0] ci_r;
  logic [4:0] op_r;
  logic signed [31:0] t_r [12];
  logic [DivIdxW-1:0] di_r;
  logic [47:0] dq_r;
  logic [32:0] drem_r;
  logic [31:0] dden_r;
  logic dneg_r, dzero_r;
  logic [135:0] odata_r;
  logic ovalid_r;
  logic [13:0] rq_r;
  logic [34:0] rm_r;

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {1'b0, regs_r[cfg_paddr[4:2]]};
  assign in_tready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  // shared multiply unit: rounded, saturated Q16.16 product
  logic signed [31:0] ma, mb, mres;
  logic signed [63:0] mprod;
  assign mprod = ma * mb;
  assign mres = sat32(66'((mprod + 64'sd32768) >>> 16));

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  logic signed [31:0] rF, rG, rM, rI, rL, rT;
  assign rF = {1'b0, regs_r[RegForce]};
  assign rG = {1'b0, regs_r[RegGrav]};
  assign rM = {1'b0, regs_r[RegMass]};
  assign rI = {1'b0, regs_r[RegInvM]};
  assign rL = {1'b0, regs_r[RegLen]};
  assign rT = {1'b0, regs_r[RegTau]};

  // t_r slots: 0 sin,1 cos,2 pml,3 w2,4 temp,5 num,6 cc,7 den,8 tacc,9 scratch
  always_comb begin
    ma = 32'sd0;
    mb = 32'sd0;
    if (state_r == ST_RED) begin
      // turns estimate for the angle reduction
      ma = ang_r; mb = RecipTwoPiQ30;
    end else begin
      unique case (op_r)
        5'd0: begin ma = rM; mb = rL; end
        5'd1: begin ma = rate_r; mb = rate_r; end
        5'd2: begin ma = t_r[2]; mb = t_r[3]; end
        5'd3: begin ma = t_r[9]; mb = t_r[0]; end
        5'd4: begin ma = qadd(push_r ? rF : -rF, t_r[9]); mb = rI; end
        5'd5: begin ma = rG; mb = t_r[0]; end
        5'd6: begin ma = t_r[1]; mb = t_r[4]; end
        5'd7: begin ma = t_r[1]; mb = t_r[1]; end
        5'd8: begin ma = rM; mb = t_r[6]; end
        5'd9: begin ma = t_r[9]; mb = rI; end
        5'd10: begin ma = rL; mb = sat32(66'(FourThirdsQ) - 66'(t_r[9])); end
        5'd11: begin ma = t_r[2]; mb = t_r[8]; end
        5'd12: begin ma = t_r[9]; mb = t_r[1]; end
        5'd13: begin ma = t_r[9]; mb = rI; end
        5'd14: begin ma = rT; mb = vel_r; end
        5'd15: begin ma = rT; mb = sat32(66'(t_r[4]) - 66'(t_r[9])); end
        5'd16: begin ma = rT; mb = rate_r; end
        5'd17: begin ma = rT; mb = t_r[8]; end
        default: begin ma = 32'sd0; mb = 32'sd0; end
      endcase
    end
  end

  // angle reduction: |angle| mod 2*pi by reciprocal estimate, then one correction
  logic [63:0] pabs;
  logic [31:0] amag;
  logic [46:0] rdiff;
  logic [34:0] rmod;
  assign pabs = mprod[63] ? 64'(-mprod) : 64'(mprod);
  assign amag = ang_r[31] ? 32'(-33'(ang_r)) : 32'(ang_r);
  assign rdiff = {1'b0, amag, 14'd0} - 47'(rq_r) * 47'(TwoPiQ30);
  assign rmod = (rm_r >= 35'(TwoPiQ30)) ? rm_r - 35'(TwoPiQ30) : rm_r;

  logic signed [35:0] red0, red1, red2, rfold;
  logic fold;
  always_comb begin
    red0 = ang_r[31] ? -$signed(36'(rmod)) : $signed(36'(rmod));
    red1 = (red0 < 0) ? red0 + TwoPiQ30 : red0;
    red2 = (red1 > PiQ30) ? red1 - TwoPiQ30 : red1;
    fold = 1'b0;
    rfold = red2;
    if (red2 > HalfPiQ30) begin
      rfold = PiQ30 - red2; fold = 1'b1;
    end else if (red2 < -HalfPiQ30) begin
      rfold = -PiQ30 - red2; fold = 1'b1;
    end
  end

  logic signed [35:0] sx, sy, xr, yr, cx_nxt, cy_nxt;
  assign sx = cx_r >>> ci_r;
  assign sy = cy_r >>> ci_r;
  assign cx_nxt = (cz_r >= 0) ? cx_r - sy : cx_r + sy;
  assign cy_nxt = (cz_r >= 0) ? cy_r + sx : cy_r - sx;
  assign xr = (cx_nxt + 36'sd8192) >>> 14;
  assign yr = (cy_nxt + 36'sd8192) >>> 14;

  logic [32:0] dtrial;
  assign dtrial = {drem_r[31:0], dq_r[47]} - {1'b0, dden_r};

  logic signed [31:0] npos, nang;
  logic signed [32:0] xl, al;
  assign xl = {2'b0, regs_r[RegXLim]};
  assign al = {2'b0, regs_r[RegALim]};
  assign npos = qadd(pos_r, t_r[10]);
  assign nang = qadd(ang_r, t_r[11]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid && in_tready && in_tuser == OpStep) state_nxt = ST_RED;
      ST_RED: begin
        if (32'(di_r) != RedIters - 1) state_nxt = ST_RED;
        else if (32'(cnt_r) + 32'd1 >= MaxSteps) state_nxt = ST_OUT;
        else state_nxt = ST_CORD;
      end
      ST_CORD: if (32'(ci_r) == CordicIters - 1) state_nxt = ST_MATH;
      ST_MATH: if (op_r == 5'd10) state_nxt = ST_DIV;
               else if (op_r == 5'd17) state_nxt = ST_OUT;
      ST_DIV: if (32'(di_r) == DivIters - 1) state_nxt = ST_MATH;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      regs_r[0] <= 31'd655360; regs_r[1] <= 31'd642253;
      regs_r[2] <= 31'd6554;   regs_r[3] <= 31'd59578;
      regs_r[4] <= 31'd32768;  regs_r[5] <= 31'd1311;
      regs_r[6] <= 31'd157286; regs_r[7] <= 31'd13726;
      pos_r <= '0; vel_r <= '0; ang_r <= '0; rate_r <= '0;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      op_r <= '0; ci_r <= '0; di_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) regs_r[cfg_paddr[4:2]] <= cfg_pwdata[30:0];
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          push_r <= in_tdata[0];
          di_r <= '0;
          if (in_tuser == OpLoad) begin
            pos_r <= in_tdata[32:1]; vel_r <= in_tdata[64:33];
            ang_r <= in_tdata[96:65]; rate_r <= in_tdata[128:97];
            cnt_r <= '0;
            odata_r <= {8'd0, in_tdata[128:1]};
            ovalid_r <= 1'b1;
          end
        end
        ST_RED: begin
          di_r <= di_r + 1'b1;
          if (di_r == 6'd0) begin
            rq_r <= pabs[62:49];
          end else if (di_r == 6'd1) begin
            rm_r <= rdiff[34:0];
          end else begin
            if (32'(cnt_r) < MaxSteps) cnt_r <= cnt_r + 1'b1;
            reward_r <= 1'b0; done_r <= 1'b1;
            cx_r <= CordicGain; cy_r <= '0; cz_r <= rfold; flip_r <= fold;
            ci_r <= '0; op_r <= '0;
          end
        end
        ST_CORD: begin
          // advance one rotation
          cx_r <= cx_nxt; cy_r <= cy_nxt;
          if (cz_r >= 0) cz_r <= cz_r - atan_q30(ci_r);
          else cz_r <= cz_r + atan_q30(ci_r);
          ci_r <= ci_r + 1'b1;
          if (32'(ci_r) == CordicIters - 1) begin
            ci_r <= '0;
            t_r[0] <= sat32(66'(yr));
            t_r[1] <= sat32(flip_r ? -66'(xr) : 66'(xr));
          end
        end
        ST_MATH: begin
          op_r <= op_r + 1'b1;
          unique case (op_r)
            5'd0: t_r[2] <= mres;
            5'd1: t_r[3] <= mres;
            5'd4: t_r[4] <= mres;
            5'd5: t_r[5] <= mres;
            5'd6: t_r[5] <= sat32(66'(t_r[5]) - 66'(mres));
            5'd7: t_r[6] <= mres;
            5'd10: begin
              t_r[7] <= mres;
              // sign-magnitude restoring division setup
              dq_r <= {(t_r[5][31] ? 32'(-33'(t_r[5])) : t_r[5]), 16'd0};
              dden_r <= mres[31] ? 32'(-33'(mres)) : mres;
              dneg_r <= t_r[5][31] ^ mres[31];
              dzero_r <= (mres == 32'sd0);
              drem_r <= '0; di_r <= '0;
            end
            5'd14: t_r[10] <= mres;
            5'd15: begin
              vel_r <= qadd(vel_r, mres);
              pos_r <= npos;
            end
            5'd16: t_r[11] <= mres;
            5'd17: begin
              rate_r <= qadd(rate_r, mres);
              ang_r <= nang;
              reward_r <= 1'b1;
              // position was already advanced at op 15
              done_r <= (66'(pos_r) < -66'(xl)) || (66'(pos_r) > 66'(xl)) ||
                        (66'(nang) < -66'(al)) || (66'(nang) > 66'(al));
            end
            default: t_r[9] <= mres;
          endcase
        end
        ST_DIV: begin
          di_r <= di_r + 1'b1;
          if (!dtrial[32]) begin
            drem_r <= dtrial; dq_r <= {dq_r[46:0], 1'b1};
          end else begin
            drem_r <= {drem_r[31:0], dq_r[47]}; dq_r <= {dq_r[46:0], 1'b0};
          end
          if (32'(di_r) == DivIters - 1) begin
            if (dzero_r) t_r[8] <= t_r[5][31] ? 32'sh80000000 : 32'sh7fffffff;
            else if (!dtrial[32])
              t_r[8] <= sat32(dneg_r ? -66'({dq_r[46:0], 1'b1})
                                     : 66'({dq_r[46:0], 1'b1}));
            else
              t_r[8] <= sat32(dneg_r ? -66'({dq_r[46:0], 1'b0})
                                     : 66'({dq_r[46:0], 1'b0}));
          end
        end
        ST_OUT: begin
          odata_r <= {6'd0, done_r, reward_r, rate_r, ang_r, vel_r, pos_r};
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("ready while busy");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MaxSteps) else $error("step counter past limit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r && $stable(odata_r))
    else $error("result dropped");
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_tready) else $error("accept with result pending");

endmodule
